// ===== rtl/pfen_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types of the packet FIFO with empty notifier.
package pfen_pkg;

  localparam int SLOTS    = 1024;
  localparam int REF_BITS = 32;
  localparam int PTR_W    = $clog2(SLOTS);
  localparam int CNT_W    = 10;
  localparam int CAP_W    = 10;
  localparam int TRIG_W   = 8;
  localparam int DROP_W   = 32;
  localparam int CFG_IDX_W = 1;

  // Most entries the queue can ever hold, limited by the count width.
  localparam int MAX_HELD = (SLOTS > (2 ** CNT_W) - 1) ? (2 ** CNT_W) - 1 : SLOTS;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TRIGGER = 1'b1;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;

  localparam logic [CAP_W-1:0]  CAPACITY_RESET     = 10'd1000;
  localparam logic [TRIG_W-1:0] IDLE_TRIGGER_RESET = 8'd9;

  typedef enum logic [1:0] {
    STAT_PUSHED  = 2'd0,
    STAT_DROPPED = 2'd1,
    STAT_PULLED  = 2'd2,
    STAT_EMPTY   = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

// ===== rtl/packet_fifo_with_empty_notifier_core.sv =====
`timescale 1ns / 1ps
// Top level of the tail-drop packet reference FIFO with empty notifier.
//
// A command is taken by start while busy is low; busy is then high for one
// cycle while the entry read from the slot memory comes back and the queue
// state is updated, and the result is shown for one cycle with done high. A
// new command may be started in that same cycle, so the block does not take
// a new command before the last one's result is out; the registered read of
// the slot memory sets this pace. Results are presented once and cannot be
// held off. The slot memory needs no clearing after reset, as an entry is
// only ever read after it has been written. Configuration writes are always
// taken and should only be made while no command is in flight.
module packet_fifo_with_empty_notifier_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            op,
  input  logic [pfen_pkg::REF_BITS-1:0]   packet_ref,
  output logic                            done,
  output logic [1:0]                      status,
  output logic [pfen_pkg::REF_BITS-1:0]   out_ref,
  output logic                            nonempty_signal,
  output logic [pfen_pkg::CNT_W-1:0]      queue_length,
  output logic [pfen_pkg::CNT_W-1:0]      high_water,
  output logic [pfen_pkg::DROP_W-1:0]     drop_count,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pfen_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfen_pkg::DROP_W-1:0]     cfg_data
);

  import pfen_pkg::*;

  state_t state, state_next;

  logic [CAP_W-1:0]  capacity;
  logic [TRIG_W-1:0] idle_trigger;

  logic                op_q;
  logic [REF_BITS-1:0] ref_q;

  logic [PTR_W-1:0]  head_index, head_index_next;
  logic [PTR_W-1:0]  tail_index, tail_index_next;
  logic [CNT_W-1:0]  held_count, held_count_next;
  logic [CNT_W-1:0]  high_mark, high_mark_next;
  logic [DROP_W-1:0] dropped_total, dropped_total_next;
  logic [TRIG_W-1:0] idle_pulls, idle_pulls_next;
  logic              awake_flag, awake_flag_next;

  status_t             res_status;
  logic [REF_BITS-1:0] res_ref;

  logic                accept;
  logic                mem_we;
  logic [REF_BITS-1:0] mem_rdata;
  logic [CNT_W-1:0]    limit;

  assign accept    = start && (state == ST_IDLE);
  assign busy      = (state == ST_EXEC);
  assign cfg_ready = 1'b1;

  // The queue never holds more entries than there are slots.
  assign limit = (capacity < CNT_W'(MAX_HELD)) ? capacity : CNT_W'(MAX_HELD);

  pfen_ram #(
    .DEPTH (SLOTS),
    .WIDTH (REF_BITS)
  ) u_slots (
    .clk   (clk),
    .we    (mem_we),
    .waddr (tail_index),
    .wdata (ref_q),
    .re    (accept),
    .raddr (head_index),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity     <= CAPACITY_RESET;
      idle_trigger <= IDLE_TRIGGER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CAPACITY:     capacity     <= cfg_data[CAP_W-1:0];
        CFG_IDLE_TRIGGER: idle_trigger <= cfg_data[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= op;
      ref_q <= packet_ref;
    end
  end

  always_comb begin
    state_next         = state;
    head_index_next    = head_index;
    tail_index_next    = tail_index;
    held_count_next    = held_count;
    high_mark_next     = high_mark;
    dropped_total_next = dropped_total;
    idle_pulls_next    = idle_pulls;
    awake_flag_next    = awake_flag;
    res_status         = STAT_PUSHED;
    res_ref            = '0;
    mem_we             = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
        if (op_q == OP_PUSH) begin
          if (held_count < limit) begin
            mem_we          = 1'b1;
            tail_index_next = (tail_index == PTR_W'(SLOTS - 1)) ? '0 : tail_index + 1'b1;
            held_count_next = held_count + 1'b1;
            if (held_count_next > high_mark) begin
              high_mark_next = held_count_next;
            end
            awake_flag_next = 1'b1;
            res_status      = STAT_PUSHED;
          end else begin
            if (dropped_total != '1) begin
              dropped_total_next = dropped_total + 1'b1;
            end
            res_ref    = ref_q;
            res_status = STAT_DROPPED;
          end
        end else begin
          if (held_count != '0) begin
            res_ref         = mem_rdata;
            head_index_next = (head_index == PTR_W'(SLOTS - 1)) ? '0 : head_index + 1'b1;
            held_count_next = held_count - 1'b1;
            idle_pulls_next = '0;
            res_status      = STAT_PULLED;
          end else begin
            if (idle_pulls >= idle_trigger) begin
              awake_flag_next = 1'b0;
            end else begin
              idle_pulls_next = idle_pulls + 1'b1;
            end
            res_status = STAT_EMPTY;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_index    <= '0;
      tail_index    <= '0;
      held_count    <= '0;
      high_mark     <= '0;
      dropped_total <= '0;
      idle_pulls    <= '0;
      awake_flag    <= 1'b1;
    end else begin
      head_index    <= head_index_next;
      tail_index    <= tail_index_next;
      held_count    <= held_count_next;
      high_mark     <= high_mark_next;
      dropped_total <= dropped_total_next;
      idle_pulls    <= idle_pulls_next;
      awake_flag    <= awake_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      status          <= res_status;
      out_ref         <= res_ref;
      nonempty_signal <= awake_flag_next;
      queue_length    <= held_count_next;
      high_water      <= high_mark_next;
      drop_count      <= dropped_total_next;
    end
  end

  // A result only ever follows a cycle in which a command was executed.
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_EXEC))
    else $error("result strobe without a preceding execute cycle");

  // An accepted command always moves on to execution in the next cycle.
  a_accept_to_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not enter execution");

  a_held_bounded: assert property (@(posedge clk) disable iff (rst)
    held_count <= CNT_W'(MAX_HELD))
    else $error("queue holds more entries than slots");

  a_push_wakes: assert property (@(posedge clk) disable iff (rst)
    (done && status == STAT_PUSHED) |-> nonempty_signal)
    else $error("successful transfer into the queue left the notifier asleep");

  a_high_water: assert property (@(posedge clk) disable iff (rst)
    done |-> (high_water >= queue_length))
    else $error("high-water mark below current queue length");

endmodule

// ===== rtl/pfen_ram.sv =====
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM with one write port and a registered read port.
module pfen_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== dv/packet_fifo_with_empty_notifier_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the packet FIFO with empty notifier, using a predicting scoreboard.
module packet_fifo_with_empty_notifier_core_tb;
  import pfen_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    status_t                st;
    logic [REF_BITS-1:0]    pkt;
    logic                   awake;
    logic [CNT_W-1:0]       len;
    logic [CNT_W-1:0]       hw;
    logic [DROP_W-1:0]      drops;
  } queue_outcome_t;

  class pkt_queue_scoreboard;
    logic [REF_BITS-1:0] slots [SLOTS];
    int unsigned         head_ptr;
    int unsigned         tail_ptr;
    int unsigned         held;
    int unsigned         high_mark;
    logic [DROP_W-1:0]   dropped;
    int unsigned         idle_pulls;
    logic                awake;
    int unsigned         capacity;
    int unsigned         idle_trigger;
    queue_outcome_t      pending_outcomes[$];
    int                  mismatches;

    function new();
      head_ptr     = 0;
      tail_ptr     = 0;
      held         = 0;
      high_mark    = 0;
      dropped      = '0;
      idle_pulls   = 0;
      awake        = 1'b1;
      capacity     = CAPACITY_RESET;
      idle_trigger = IDLE_TRIGGER_RESET;
      mismatches   = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [DROP_W-1:0] val);
      if (idx == CFG_CAPACITY) begin
        capacity = val[CAP_W-1:0];
      end else if (idx == CFG_IDLE_TRIGGER) begin
        idle_trigger = val[TRIG_W-1:0];
      end
    endfunction

    function int pending();
      return pending_outcomes.size();
    endfunction

    // Works out the outcome of one accepted command and queues it.
    function void note_command(logic cmd_op, logic [REF_BITS-1:0] pkt_in);
      queue_outcome_t r;
      int unsigned    limit;
      r.pkt = '0;
      limit = (capacity < SLOTS) ? capacity : SLOTS;
      if (cmd_op == OP_PUSH) begin
        if (held < limit) begin
          slots[tail_ptr] = pkt_in;
          tail_ptr = (tail_ptr + 1) % SLOTS;
          held++;
          if (held > high_mark) high_mark = held;
          awake = 1'b1;
          r.st = STAT_PUSHED;
        end else begin
          if (dropped != '1) dropped++;
          r.pkt = pkt_in;
          r.st = STAT_DROPPED;
        end
      end else begin
        if (held > 0) begin
          r.pkt = slots[head_ptr];
          head_ptr = (head_ptr + 1) % SLOTS;
          held--;
          idle_pulls = 0;
          r.st = STAT_PULLED;
        end else begin
          // The signal is only lowered once the idle count has reached the trigger.
          if (idle_pulls >= idle_trigger) awake = 1'b0;
          else idle_pulls = (idle_pulls + 1) & 8'hFF;
          r.st = STAT_EMPTY;
        end
      end
      r.awake = awake;
      r.len   = held[CNT_W-1:0];
      r.hw    = high_mark[CNT_W-1:0];
      r.drops = dropped;
      pending_outcomes.push_back(r);
    endfunction

    function void check_result(queue_outcome_t got);
      queue_outcome_t want;
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: status %0d ref %h", $realtime, got.st, got.pkt);
        return;
      end
      want = pending_outcomes.pop_front();
      if (got.st !== want.st || got.pkt !== want.pkt || got.awake !== want.awake ||
          got.len !== want.len || got.hw !== want.hw || got.drops !== want.drops) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] mismatch (expected/actual): status %0d/%0d ref %h/%h awake %b/%b",
                   $realtime, want.st, got.st, want.pkt, got.pkt, want.awake, got.awake);
          $display("    length %0d/%0d high water %0d/%0d drops %0d/%0d",
                   want.len, got.len, want.hw, got.hw, want.drops, got.drops);
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst        = 1'b1;
  logic                  start      = 1'b0;
  logic                  busy;
  logic                  op         = OP_PUSH;
  logic [REF_BITS-1:0]   packet_ref = '0;
  logic                  done;
  logic [1:0]            status;
  logic [REF_BITS-1:0]   out_ref;
  logic                  nonempty_signal;
  logic [CNT_W-1:0]      queue_length;
  logic [CNT_W-1:0]      high_water;
  logic [DROP_W-1:0]     drop_count;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = CFG_CAPACITY;
  logic [DROP_W-1:0]     cfg_data   = '0;

  pkt_queue_scoreboard sb = new();
  int                  gap_pct = 0;
  longint              cycles  = 0;

  packet_fifo_with_empty_notifier_core dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .op              (op),
    .packet_ref      (packet_ref),
    .done            (done),
    .status          (status),
    .out_ref         (out_ref),
    .nonempty_signal (nonempty_signal),
    .queue_length    (queue_length),
    .high_water      (high_water),
    .drop_count      (drop_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("packet_fifo_with_empty_notifier_core regression: fail");
      $finish;
    end
  end

  // Outputs are sampled at the edge, before that edge's updates land.
  always @(posedge clk) begin
    if (!rst && done)
      sb.check_result('{status_t'(status), out_ref, nonempty_signal,
                        queue_length, high_water, drop_count});
  end

  function automatic logic [REF_BITS-1:0] pick_ref();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return $urandom();
  endfunction

  task automatic issue_command(input logic cmd_op, input logic [REF_BITS-1:0] pkt);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    op         <= cmd_op;
    packet_ref <= pkt;
    do @(posedge clk); while (busy);
    sb.note_command(cmd_op, pkt);
  endtask

  // Holds the sender off until every outstanding result has been seen.
  task automatic drain_results();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Both registers in one burst; the upper data bits are junk that must be ignored.
  task automatic set_queue_config(input int unsigned cap, input int unsigned trig);
    logic [DROP_W-1:0] val;
    drain_results();
    val = $urandom();
    val[CAP_W-1:0] = CAP_W'(cap);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_CAPACITY;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(CFG_CAPACITY, val);
    val = $urandom();
    val[TRIG_W-1:0] = TRIG_W'(trig);
    cfg_index <= CFG_IDLE_TRIGGER;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(CFG_IDLE_TRIGGER, val);
    cfg_valid <= 1'b0;
  endtask

  // Bursts of one operation with random content, so the queue fills and drains.
  task automatic run_phase(input int unsigned cap, input int unsigned trig,
                           input int gaps, input int push_pct, input int items);
    int   left;
    int   burst;
    logic burst_op;
    set_queue_config(cap, trig);
    gap_pct = gaps;
    left = items;
    while (left > 0) begin
      burst_op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_PULL;
      burst = $urandom_range(1, 8);
      if (burst > left) burst = left;
      for (int i = 0; i < burst; i++) begin
        issue_command(burst_op, pick_ref());
        left--;
        if (left == items / 2 || $urandom_range(99) < 2) drain_results();
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: idle trigger at its reset value, reference extremes, zero capacity.
    gap_pct = 0;
    for (int i = 0; i < 11; i++) issue_command(OP_PULL, $urandom());
    issue_command(OP_PUSH, '0);
    issue_command(OP_PUSH, '1);
    issue_command(OP_PUSH, 32'hA5A5_A5A5);
    for (int i = 0; i < 4; i++) issue_command(OP_PULL, '1);
    set_queue_config(0, 0);
    issue_command(OP_PUSH, '1);
    issue_command(OP_PULL, '0);
    set_queue_config(1, 0);
    issue_command(OP_PUSH, 32'h5A5A_5A5A);
    issue_command(OP_PUSH, 32'h0F0F_F0F0);
    issue_command(OP_PULL, '0);
    issue_command(OP_PULL, '0);
    issue_command(OP_PUSH, 32'h1234_5678);

    run_phase(4, 2, 0, 55, 90);
    run_phase(1023, 255, 65, 60, 90);
    run_phase($urandom_range(1, 12), $urandom_range(0, 6), 37, 50, 90);
    run_phase(0, 0, 0, 50, 40);
    run_phase($urandom_range(1, 32), $urandom_range(0, 255), 65, 45, 90);
    run_phase(1, 1, 37, 50, 80);
    run_phase(16, 8, 0, 50, 80);

    drain_results();
    repeat (6) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("packet_fifo_with_empty_notifier_core regression: pass");
    end else begin
      $display("packet_fifo_with_empty_notifier_core regression: fail");
    end
    $finish;
  end

endmodule
